>>> design/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Types and constants shared by the Rice stream decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rsd_pkg;

  localparam int unsigned BYTE_BITS = 8;

  localparam logic [1:0] HDR_DONE = 2'd3;
  localparam logic [2:0] LAST_BIT = 3'd7;
  localparam logic       BIT_ONE  = 1'b1;

  typedef struct packed {
    logic                 last;
    logic [BYTE_BITS-1:0] data;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] symbol;
    logic                 padded;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic pop;       // head byte fully consumed this cycle
    logic hdr_idle;  // header counter at its start value
  } eng_stat_t;

endpackage

`default_nettype wire

>>> design/rsd_fifo.sv
// ----------------------------------------------------------------------------
// rsd_fifo
// Small register FIFO used for the byte queue and the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> design/rsd_decode.sv
// ----------------------------------------------------------------------------
// rsd_decode
// Bit-serial back end: one stream bit per cycle from the head byte unless
// stalled, with a one-entry hold stage that marks each byte's last symbol.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                bit_avail,
  input  rsd_pkg::in_item_t   head,
  input  logic                out_full,
  output logic                push,
  output rsd_pkg::result_t    push_res,
  output rsd_pkg::eng_stat_t  stat
);

  logic [1:0] hdr_r, hdr_nxt;
  logic [2:0] k_r, k_nxt;
  logic       inrem_r, inrem_nxt;
  logic [7:0] q_r, q_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [2:0] left_r, left_nxt;
  logic [2:0] bidx_r;

  logic             pend_v_r, pend_v_nxt;
  rsd_pkg::result_t pend_r, pend_nxt;

  logic       b, byte_end, emit_bit, emit_pad, n_v, push_req, go;
  logic [2:0] left_dec;
  logic [7:0] acc_or, nsym;

  assign b        = head.data[bidx_r];
  assign byte_end = bit_avail && (bidx_r == rsd_pkg::LAST_BIT);
  assign left_dec = left_r - 3'd1;
  assign acc_or   = acc_r | (8'(b) << left_dec);

  always_comb begin
    hdr_nxt   = hdr_r;
    k_nxt     = k_r;
    inrem_nxt = inrem_r;
    q_nxt     = q_r;
    acc_nxt   = acc_r;
    left_nxt  = left_r;
    emit_bit  = 1'b0;
    emit_pad  = 1'b0;
    nsym      = acc_r;
    if (bit_avail) begin
      priority if (hdr_r != rsd_pkg::HDR_DONE) begin
        k_nxt   = {k_r[1:0], b};
        hdr_nxt = hdr_r + 2'd1;
      end else if (!inrem_r) begin
        if (b == rsd_pkg::BIT_ONE) begin
          q_nxt = q_r + 8'd1;
        end else if (k_r == '0) begin
          emit_bit = 1'b1;
          nsym     = q_r;
          q_nxt    = '0;
        end else begin
          acc_nxt   = q_r << k_r;
          left_nxt  = k_r;
          inrem_nxt = 1'b1;
          q_nxt     = '0;
        end
      end else begin
        left_nxt = left_dec;
        acc_nxt  = acc_or;
        if (left_dec == '0) begin
          emit_bit  = 1'b1;
          nsym      = acc_or;
          inrem_nxt = 1'b0;
          acc_nxt   = '0;
        end
      end
      if (byte_end && head.last) begin
        if (inrem_nxt && (left_nxt != '0)) begin
          emit_pad = 1'b1;
          nsym     = acc_nxt;
        end
        hdr_nxt   = '0;
        k_nxt     = '0;
        inrem_nxt = 1'b0;
        q_nxt     = '0;
        acc_nxt   = '0;
        left_nxt  = '0;
      end
    end
  end

  assign n_v      = emit_bit || emit_pad;
  assign push_req = pend_v_r && (pend_r.last || n_v || byte_end);
  assign go       = !(push_req && out_full);
  assign push     = push_req && go;

  always_comb begin
    push_res        = pend_r;
    push_res.last   = pend_r.last || (byte_end && !n_v);
    pend_v_nxt      = pend_v_r;
    pend_nxt        = pend_r;
    if (go) begin
      if (n_v) begin
        pend_v_nxt      = 1'b1;
        pend_nxt.symbol = nsym;
        pend_nxt.padded = emit_pad;
        pend_nxt.last   = byte_end;
      end else if (push) begin
        pend_v_nxt = 1'b0;
      end
    end
  end

  assign stat.pop      = go && byte_end;
  assign stat.hdr_idle = (hdr_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r    <= '0;
      k_r      <= '0;
      inrem_r  <= 1'b0;
      q_r      <= '0;
      acc_r    <= '0;
      left_r   <= '0;
      bidx_r   <= '0;
      pend_v_r <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      if (go && bit_avail) begin
        hdr_r   <= hdr_nxt;
        k_r     <= k_nxt;
        inrem_r <= inrem_nxt;
        q_r     <= q_nxt;
        acc_r   <= acc_nxt;
        left_r  <= left_nxt;
        bidx_r  <= bidx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

endmodule

`default_nettype wire

>>> design/rice_stream_decoder.sv
// ----------------------------------------------------------------------------
// rice_stream_decoder
// Rice stream decoder: bytes in, decoded symbols out, each channel a queue.
//
//   channel  ports                                          direction
//   input    in_push in_full in_compressed_byte in_last_byte   in
//   result   out_pop out_empty out_symbol out_padded           out
//            out_last_in_run
//
// The bit-serial back end takes one stream bit per cycle unless stalled; a
// byte queue in front lets the next bytes be taken meanwhile.
// Results pass a one-entry hold stage and a result queue; a symbol waits
// there for the next symbol or the last bit of its byte, and the last
// symbol of each byte is marked as such.
// Reset is synchronous, active low, and empties both queues.
// A full result queue stalls the back end; the byte queue then fills.
// ----------------------------------------------------------------------------
`default_nettype none

module rice_stream_decoder #(
  parameter int unsigned IN_DEPTH  = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_compressed_byte,
  input  logic       in_last_byte,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_symbol,
  output logic       out_padded,
  output logic       out_last_in_run
);

  rsd_pkg::in_item_t  in_item, head;
  rsd_pkg::result_t   push_res, out_res;
  rsd_pkg::eng_stat_t stat;
  logic               in_empty, oq_push, oq_full;

  assign in_item.data = in_compressed_byte;
  assign in_item.last = in_last_byte;

  rsd_fifo #(
    .WIDTH ($bits(rsd_pkg::in_item_t)),
    .DEPTH (IN_DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (in_item),
    .pop   (stat.pop),
    .rdata (head),
    .full  (in_full),
    .empty (in_empty)
  );

  rsd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .bit_avail (!in_empty),
    .head      (head),
    .out_full  (oq_full),
    .push      (oq_push),
    .push_res  (push_res),
    .stat      (stat)
  );

  rsd_fifo #(
    .WIDTH ($bits(rsd_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (push_res),
    .pop   (out_pop),
    .rdata (out_res),
    .full  (oq_full),
    .empty (out_empty)
  );

  assign out_symbol      = out_res.symbol;
  assign out_padded      = out_res.padded;
  assign out_last_in_run = out_res.last;

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(oq_push && oq_full))
    else $error("result pushed into full queue");

  a_pad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_padded) |-> out_last_in_run)
    else $error("padded symbol not last of its byte");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.pop && head.last) |=> stat.hdr_idle)
    else $error("stream end did not restart header");

endmodule

`default_nettype wire

>>> tb/sv/rice_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rice_stream_decoder_tb
// Self-checking bench for the Rice stream decoder. Bytes are pushed as
// directed corner cases, then as random well-formed streams (random k,
// quotients including counter wrap, optional truncation) mixed with noise
// bytes. A scoreboard decodes each accepted byte bit by bit and checks every
// popped symbol in order. Both handshake sides idle at random.
// ----------------------------------------------------------------------------

module rice_stream_decoder_tb;

  class rice_scoreboard;
    rsd_pkg::result_t expected_q[$];
    logic [1:0] hdr_taken;
    logic [2:0] k;
    logic       in_rem;
    logic [7:0] quot;
    logic [7:0] accum;
    logic [2:0] rem_left;
    int         errors;
    int         n_bytes;
    int         n_symbols;
    int         n_padded;

    function void clear_state();
      hdr_taken = '0;
      k         = '0;
      in_rem    = 1'b0;
      quot      = '0;
      accum     = '0;
      rem_left  = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Decode one accepted byte, LSB first, and queue the symbols it yields.
    function void note_byte(logic [7:0] data, logic last_byte);
      rsd_pkg::result_t found[$];
      rsd_pkg::result_t r;
      logic    b;
      n_bytes++;
      for (int i = 0; i < 8; i++) begin
        b = data[i];
        if (hdr_taken != rsd_pkg::HDR_DONE) begin
          k = {k[1:0], b};
          hdr_taken = hdr_taken + 2'd1;
        end else if (!in_rem) begin
          if (b == rsd_pkg::BIT_ONE) begin
            quot = quot + 8'd1;
          end else if (k == 3'd0) begin
            r = '{symbol: quot, padded: 1'b0, last: 1'b0};
            found.push_back(r);
            quot = '0;
          end else begin
            accum    = quot << k;
            rem_left = k;
            in_rem   = 1'b1;
            quot     = '0;
          end
        end else begin
          rem_left = rem_left - 3'd1;
          accum    = accum | ({7'd0, b} << rem_left);
          if (rem_left == 3'd0) begin
            r = '{symbol: accum, padded: 1'b0, last: 1'b0};
            found.push_back(r);
            in_rem = 1'b0;
            accum  = '0;
          end
        end
      end
      if (last_byte) begin
        if (in_rem && rem_left != 3'd0 && found.size() < 8) begin
          r = '{symbol: accum, padded: 1'b1, last: 1'b0};
          found.push_back(r);
          n_padded++;
        end
        clear_state();
      end
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[i]) expected_q.push_back(found[i]);
    endfunction

    function void check_symbol(logic [7:0] symbol, logic padded, logic last_flag);
      rsd_pkg::result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected symbol %02h padded %0b last %0b",
                 $time, symbol, padded, last_flag);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      n_symbols++;
      if (symbol !== exp_r.symbol) begin
        $display("%0t: symbol mismatch: expected %02h, got %02h",
                 $time, exp_r.symbol, symbol);
        errors++;
      end
      if (padded !== exp_r.padded) begin
        $display("%0t: padded mismatch: expected %0b, got %0b",
                 $time, exp_r.padded, padded);
        errors++;
      end
      if (last_flag !== exp_r.last) begin
        $display("%0t: last_in_run mismatch: expected %0b, got %0b",
                 $time, exp_r.last, last_flag);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_compressed_byte = '0;
  logic       in_last_byte = 1'b0;
  logic       out_pop = 1'b0;
  logic       out_empty;
  logic [7:0] out_symbol;
  logic       out_padded;
  logic       out_last_in_run;

  rice_scoreboard sb = new();
  bit             in_steady;
  bit             out_steady;
  int             n_streams;

  // {last, byte}
  logic [8:0] directed_items[$] = '{
    9'h000, 9'h0FF, 9'h000, 9'h1E7, 9'h007, 9'h0FE, 9'h17F, 9'h103, 9'h105,
    9'h004, 9'h055, 9'h1AA, 9'h006, 9'h0F0, 9'h10F, 9'h180, 9'h1FF
  };

  rice_stream_decoder u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_compressed_byte(in_compressed_byte),
    .in_last_byte      (in_last_byte),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_symbol        (out_symbol),
    .out_padded        (out_padded),
    .out_last_in_run   (out_last_in_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_byte(input logic [7:0] data, input logic last_byte);
    int gap;
    gap = in_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push            <= 1'b1;
    in_compressed_byte <= data;
    in_last_byte       <= last_byte;
    do @(posedge clk); while (in_full);
    sb.note_byte(data, last_byte);
  endtask

  // Well-formed stream with random content, sometimes cut short.
  task automatic send_stream();
    bit         bits[$];
    int         k;
    int         nsym;
    int         q;
    int         big_at;
    int         cut;
    int         nbytes;
    logic [7:0] rem;
    logic [7:0] data;
    k = $urandom_range(0, 7);
    for (int i = 2; i >= 0; i--) bits.push_back(k[i]);
    nsym   = $urandom_range(1, 12);
    big_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nsym - 1) : -1;
    for (int s = 0; s < nsym; s++) begin
      if (s == big_at) q = $urandom_range(250, 270);
      else if ($urandom_range(0, 9) < 8) q = $urandom_range(0, 3);
      else q = $urandom_range(4, 20);
      repeat (q) bits.push_back(1'b1);
      bits.push_back(1'b0);
      rem = 8'($urandom);
      for (int i = k - 1; i >= 0; i--) bits.push_back(rem[i]);
    end
    if ($urandom_range(0, 9) < 3) begin
      cut = $urandom_range(3, bits.size());
      while (bits.size() > cut) void'(bits.pop_back());
    end
    while (bits.size() % 8 != 0) bits.push_back(1'($urandom_range(0, 1)));
    nbytes = bits.size() / 8;
    for (int j = 0; j < nbytes; j++) begin
      for (int i = 0; i < 8; i++) data[i] = bits[j*8 + i];
      push_byte(data, j == nbytes - 1);
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 4);
    for (int j = 0; j < n; j++)
      push_byte(8'($urandom), (j == n - 1) || ($urandom_range(0, 4) == 0));
  endtask

  initial begin
    sb.clear_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_items[i]) push_byte(directed_items[i][7:0], directed_items[i][8]);
    while (sb.n_bytes < 145) begin
      n_streams++;
      in_steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 15) send_noise();
      else send_stream();
    end
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Pushed %0d bytes in %0d random streams; checked %0d symbols, %0d zero-padded",
             sb.n_bytes, n_streams, sb.n_symbols, sb.n_padded);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 49) == 0) out_steady = !out_steady;
      gap = out_steady ? 0 : pick_gap();
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      sb.check_symbol(out_symbol, out_padded, out_last_in_run);
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d requests outstanding", sb.pending());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
